[design/sha224_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha224_pkg
// shared constants, command/status types and a rotate helper
// ----------------------------------------------------------------------------
package sha224_pkg;

    localparam int unsigned WordW    = 32;
    localparam int unsigned BlkWords = 16;
    localparam int unsigned Rounds   = 64;
    localparam int unsigned DigWords = 7;

    typedef logic [WordW-1:0] t_word;

    localparam t_word InitValue [8] = '{
        32'hc1059ed8, 32'h367cd507, 32'h3070dd17, 32'hf70e5939,
        32'hffc00b31, 32'h68581511, 32'h64f98fa7, 32'hbefa4fa4
    };

    localparam t_word PadByte = 32'h8000_0000;

    localparam t_word RoundK [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    // buffer write source chosen by the controller
    typedef enum logic [2:0] {
        BUF_NONE,
        BUF_WORD,     // full message word
        BUF_PARTIAL,  // masked word with pad byte
        BUF_PAD,      // pad byte alone
        BUF_ZERO,
        BUF_LEN_HI,
        BUF_LEN_LO
    } t_buf_src;

    typedef struct packed {
        t_buf_src   buf_src;
        logic [3:0] buf_addr;
        logic       len_add;     // add byte count to bit length
        logic       comp_start;  // load working vars and schedule
        logic       round_en;
        logic [5:0] round_idx;
        logic       chain_add;
        logic       chain_init;  // back to initial values, length cleared
        logic       out_load;
        logic [2:0] out_idx;
    } t_cmd;

    typedef struct packed {
        logic out_full;
    } t_stat;

    function automatic t_word rotr(t_word x, int unsigned n);
        return (x >> n) | (x << (WordW - n));
    endfunction

endpackage

[design/sha224_datapath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha224_datapath
// block buffer, message schedule, round unit, chain value and output register
// ----------------------------------------------------------------------------
module sha224_datapath (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  sha224_pkg::t_cmd      i_cmd,
    input  logic [31:0]           i_message_word,
    input  logic [2:0]            i_nb,
    output sha224_pkg::t_stat     o_stat,
    input  logic                  i_out_ready,
    output logic                  o_out_valid,
    output logic [31:0]           o_digest_word,
    output logic [2:0]            o_word_index,
    output logic                  o_last_digest_word
);
    import sha224_pkg::*;

    t_word      r_buf [BlkWords];
    t_word      r_w   [BlkWords];
    t_word      r_v   [8];
    t_word      r_chain [8];
    logic [63:0] r_len;
    logic       r_out_valid;
    t_word      r_out_word;
    logic [2:0] r_out_idx;

    t_word n_bufw;
    t_word keep;
    t_word w_cur, w15, w2, s0, s1, t1, t2;
    logic [3:0] nr;

    always_comb begin
        keep = '0;
        unique case (i_nb)
            3'd1:    keep = 32'hff00_0000;
            3'd2:    keep = 32'hffff_0000;
            3'd3:    keep = 32'hffff_ff00;
            default: keep = '0;
        endcase
        n_bufw = '0;
        unique case (i_cmd.buf_src)
            BUF_WORD:    n_bufw = i_message_word;
            BUF_PARTIAL: n_bufw = (i_message_word & keep) | (PadByte >> {i_nb, 3'b000});
            BUF_PAD:     n_bufw = PadByte;
            BUF_LEN_HI:  n_bufw = r_len[63:32];
            BUF_LEN_LO:  n_bufw = r_len[31:0];
            default:     n_bufw = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.buf_src != BUF_NONE) begin
            r_buf[i_cmd.buf_addr] <= n_bufw;
        end
    end

    // schedule and round
    always_comb begin
        nr  = i_cmd.round_idx[3:0];
        w15 = r_w[nr + 4'd1];
        w2  = r_w[nr + 4'd14];
        s0  = rotr(w15, 7) ^ rotr(w15, 18) ^ (w15 >> 3);
        s1  = rotr(w2, 17) ^ rotr(w2, 19) ^ (w2 >> 10);
        if (i_cmd.round_idx < 6'd16) begin
            w_cur = r_w[nr];
        end else begin
            w_cur = s0 + r_w[nr] + s1 + r_w[nr + 4'd9];
        end
        t1 = r_v[7] + (rotr(r_v[4], 6) ^ rotr(r_v[4], 11) ^ rotr(r_v[4], 25))
           + ((r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6])) + RoundK[i_cmd.round_idx] + w_cur;
        t2 = (rotr(r_v[0], 2) ^ rotr(r_v[0], 13) ^ rotr(r_v[0], 22))
           + ((r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]));
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.comp_start) begin
            r_w <= r_buf;
            r_v <= r_chain;
        end else if (i_cmd.round_en) begin
            r_w[nr] <= w_cur;
            r_v[0] <= t1 + t2;
            r_v[1] <= r_v[0];
            r_v[2] <= r_v[1];
            r_v[3] <= r_v[2];
            r_v[4] <= r_v[3] + t1;
            r_v[5] <= r_v[4];
            r_v[6] <= r_v[5];
            r_v[7] <= r_v[6];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chain <= InitValue;
            r_len   <= '0;
        end else begin
            if (i_cmd.chain_init) begin
                r_chain <= InitValue;
                r_len   <= '0;
            end else begin
                if (i_cmd.chain_add) begin
                    for (int i = 0; i < 8; i++) begin
                        r_chain[i] <= r_chain[i] + r_v[i];
                    end
                end
                if (i_cmd.len_add) begin
                    r_len <= r_len + {58'd0, i_nb, 3'b000};
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
        if (i_cmd.out_load) begin
            r_out_word <= r_chain[i_cmd.out_idx];
            r_out_idx  <= i_cmd.out_idx;
        end
    end

    assign o_stat.out_full     = r_out_valid && !i_out_ready;
    assign o_out_valid         = r_out_valid;
    assign o_digest_word       = r_out_word;
    assign o_word_index        = r_out_idx;
    assign o_last_digest_word  = (r_out_idx == 3'(DigWords - 1));

    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |-> !(r_out_valid && !i_out_ready))
        else $error("output register overwritten");
    a_no_mix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_cmd.round_en && i_cmd.comp_start))
        else $error("round during schedule load");
    a_init_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.chain_init |-> !i_cmd.chain_add && !i_cmd.len_add)
        else $error("chain init clashes");

endmodule

[design/sha224_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha224_ctrl
// sequencer for word intake, padding, compression rounds and digest output
// ----------------------------------------------------------------------------
module sha224_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [2:0]            i_valid_bytes,
    input  logic                  i_final_word,
    output logic [2:0]            o_nb,
    input  sha224_pkg::t_stat     i_stat,
    output sha224_pkg::t_cmd      o_cmd
);
    import sha224_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE, S_START, S_ROUND, S_ADD, S_FILL, S_OUT
    } t_state;

    t_state     r_state;
    logic [3:0] r_pos;
    logic [5:0] r_round;
    logic [3:0] r_fill;
    logic [2:0] r_oidx;
    logic       r_fin;    // padding in progress
    logic       r_pad;    // pad byte still owed
    logic       r_last;   // this compression carries the length

    logic       acc;
    logic [2:0] nb;

    assign o_in_ready = (r_state == S_IDLE);
    assign acc        = i_in_valid && o_in_ready;
    assign nb = (!i_final_word || i_valid_bytes > 3'd4) ? 3'd4 : i_valid_bytes;
    assign o_nb = nb;

    always_comb begin
        o_cmd            = '0;
        o_cmd.buf_src    = BUF_NONE;
        o_cmd.buf_addr   = r_pos;
        o_cmd.round_idx  = r_round;
        o_cmd.out_idx    = r_oidx;
        unique case (r_state)
            S_IDLE: begin
                if (acc) begin
                    o_cmd.len_add = 1'b1;
                    o_cmd.buf_src = (nb == 3'd4) ? BUF_WORD : BUF_PARTIAL;
                end
            end
            S_START: o_cmd.comp_start = 1'b1;
            S_ROUND: o_cmd.round_en = 1'b1;
            S_ADD:   o_cmd.chain_add = 1'b1;
            S_FILL: begin
                o_cmd.buf_addr = r_fill;
                if (r_pad) begin
                    o_cmd.buf_src = BUF_PAD;
                end else if (r_fill == 4'd14 && r_last) begin
                    o_cmd.buf_src = BUF_LEN_HI;
                end else if (r_fill == 4'd15 && r_last) begin
                    o_cmd.buf_src = BUF_LEN_LO;
                end else begin
                    o_cmd.buf_src = BUF_ZERO;
                end
            end
            S_OUT: begin
                if (!i_stat.out_full) begin
                    o_cmd.out_load = 1'b1;
                    if (r_oidx == 3'(DigWords - 1)) begin
                        o_cmd.chain_init = 1'b1;
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_pos   <= '0;
            r_round <= '0;
            r_fill  <= '0;
            r_oidx  <= '0;
            r_fin   <= 1'b0;
            r_pad   <= 1'b0;
            r_last  <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (acc) begin
                        if (!i_final_word) begin
                            r_pos <= r_pos + 4'd1;
                            if (r_pos == 4'd15) begin
                                r_state <= S_START;
                            end
                        end else begin
                            r_fin <= 1'b1;
                            if (nb == 3'd4) begin
                                r_pad <= 1'b1;
                                if (r_pos == 4'd15) begin
                                    r_last  <= 1'b0;
                                    r_state <= S_START;
                                end else begin
                                    r_fill  <= r_pos + 4'd1;
                                    r_last  <= (r_pos < 4'd13);
                                    r_state <= S_FILL;
                                end
                            end else if (r_pos == 4'd15) begin
                                r_last  <= 1'b0;
                                r_state <= S_START;
                            end else begin
                                r_fill  <= r_pos + 4'd1;
                                r_last  <= (r_pos < 4'd14);
                                r_state <= S_FILL;
                            end
                        end
                    end
                end
                S_FILL: begin
                    r_pad  <= 1'b0;
                    r_fill <= r_fill + 4'd1;
                    if (r_fill == 4'd15) begin
                        r_state <= S_START;
                    end
                end
                S_START: begin
                    r_round <= '0;
                    r_state <= S_ROUND;
                end
                S_ROUND: begin
                    r_round <= r_round + 6'd1;
                    if (r_round == 6'(Rounds - 1)) begin
                        r_state <= S_ADD;
                    end
                end
                S_ADD: begin
                    r_pos <= '0;
                    if (!r_fin) begin
                        r_state <= S_IDLE;
                    end else if (r_last) begin
                        r_oidx  <= '0;
                        r_state <= S_OUT;
                    end else begin
                        r_fill  <= '0;
                        r_last  <= 1'b1;
                        r_state <= S_FILL;
                    end
                end
                S_OUT: begin
                    if (!i_stat.out_full) begin
                        r_oidx <= r_oidx + 3'd1;
                        if (r_oidx == 3'(DigWords - 1)) begin
                            r_fin   <= 1'b0;
                            r_last  <= 1'b0;
                            r_state <= S_IDLE;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_round_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ROUND) && (r_round == 6'(Rounds - 1)) |=> r_state == S_ADD)
        else $error("round count overrun");
    a_pad_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pad |-> r_fin)
        else $error("pad owed outside final");
    a_out_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT) |-> r_fin && r_last)
        else $error("digest without length block");

endmodule

[design/sha224_digest_engine_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha224_digest_engine_core
// sha-224 hash of a word stream, digest given as seven beats
// a non-final word is written to the block buffer; a full block then runs a compression
// final word: pad, zero and length fill, then one or two compressions (start, rounds, add)
// words are not taken while a block is compressed by the one-round-per-cycle unit
// reset: synchronous active low, chain to initial values, length and pointer cleared
// ----------------------------------------------------------------------------
module sha224_digest_engine_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [31:0] i_message_word,
    input  logic [2:0]  i_valid_bytes,
    input  logic        i_final_word,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [31:0] o_digest_word,
    output logic [2:0]  o_word_index,
    output logic        o_last_digest_word
);
    import sha224_pkg::*;

    t_cmd       cmd;
    t_stat      stat;
    logic [2:0] nb;

    sha224_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_valid),
        .o_in_ready    (o_ready),
        .i_valid_bytes (i_valid_bytes),
        .i_final_word  (i_final_word),
        .o_nb          (nb),
        .i_stat        (stat),
        .o_cmd         (cmd)
    );

    sha224_datapath u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (cmd),
        .i_message_word     (i_message_word),
        .i_nb               (nb),
        .o_stat             (stat),
        .i_out_ready        (i_ready),
        .o_out_valid        (o_valid),
        .o_digest_word      (o_digest_word),
        .o_word_index       (o_word_index),
        .o_last_digest_word (o_last_digest_word)
    );

endmodule
